// File: hdl/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce and click classifier package
// Shared widths and the codes for item kinds, click phases, gestures and
// configuration register indexes.
// ----------------------------------------------------------------------------
package bdcc_pkg;

    localparam int CNT_W   = 16;
    localparam int FUNC_W  = 2;
    localparam int PHASE_W = 3;
    localparam int GEST_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd2;

    // Click phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RELEASED = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SINGLE   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DOUBLE   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LONG     = 3'd5;
    localparam logic [PHASE_W-1:0] PH_HANDLED  = 3'd6;

    // Gestures
    localparam logic [GEST_W-1:0] G_NONE   = 2'd0;
    localparam logic [GEST_W-1:0] G_SINGLE = 2'd1;
    localparam logic [GEST_W-1:0] G_DOUBLE = 2'd2;
    localparam logic [GEST_W-1:0] G_LONG   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd2;

    // Reset values of the thresholds
    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CNT_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CNT_W-1:0] DOUBLE_RST   = 16'd300;

    typedef logic [CNT_W-1:0] cnt_t;

    // Saturating increment of a tick counter.
    function automatic cnt_t sat_inc(input cnt_t v);
        cnt_t r;
        r = (v == '1) ? v : v + cnt_t'(1);
        return r;
    endfunction

endpackage

// File: hdl/button_debounce_click_classifier_top.sv
// ----------------------------------------------------------------------------
// Button debounce and click classifier
// Qualifies a push-button level and classifies single, double and long clicks.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the word kind
//   (pin edge, timer tick or poll step) and s_tdata the raw pin level.
//   Every input word yields exactly one output word on m_tvalid/m_tready,
//   holding the gesture seen by a poll (none for edges and ticks) and the
//   debounced level after the word.
//   Throughput is one word per cycle while the receiver keeps up. A word accepted
//   is captured in the input register, processed into the result register, and
//   its result is presented on m_tdata from then on.
//   When the receiver stalls, the result register holds its word and the input
//   register holds the next one; s_tready then drops until m_tready returns.
//   Reset clears the valid flags of both registers, the debouncer and the click
//   state machine (idle, confirmed low) and loads the default thresholds.
//   Thresholds are written on cfg_we/cfg_index/cfg_data while no word is in
//   flight; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module button_debounce_click_classifier_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] pin_level
    input  logic [bdcc_pkg::FUNC_W-1:0]   s_tuser,   // [1:0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [1:0] gesture, [2] confirmed_level
    input  logic                          cfg_we,
    input  logic [bdcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdcc_pkg::CNT_W-1:0]    cfg_data
);

    // Thresholds
    logic [bdcc_pkg::CNT_W-1:0] debounce_ticks_reg;
    logic [bdcc_pkg::CNT_W-1:0] long_ticks_reg;
    logic [bdcc_pkg::CNT_W-1:0] double_ticks_reg;

    // Input register
    logic                        in_valid_reg;
    logic [bdcc_pkg::FUNC_W-1:0] func_reg;
    logic                        pin_reg;

    // Block state
    logic                         sampled_reg, sampled_next;
    logic                         debounced_reg, debounced_next;
    logic [bdcc_pkg::CNT_W-1:0]   db_count_reg, db_count_next;
    logic                         db_active_reg, db_active_next;
    logic [bdcc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [bdcc_pkg::CNT_W-1:0]   click_count_reg, click_count_next;
    logic                         timer_reg, timer_next;

    // Result register
    logic                        out_valid_reg;
    logic [bdcc_pkg::GEST_W-1:0] gesture_reg, gesture_next;
    logic                        level_reg;

    logic advance;
    logic step;
    logic [bdcc_pkg::CNT_W-1:0] db_inc;
    logic [bdcc_pkg::CNT_W-1:0] click_inc;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, level_reg, gesture_reg};

    assign db_inc    = bdcc_pkg::sat_inc(db_count_reg);
    assign click_inc = bdcc_pkg::sat_inc(click_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= bdcc_pkg::DEBOUNCE_RST;
            long_ticks_reg     <= bdcc_pkg::LONG_RST;
            double_ticks_reg   <= bdcc_pkg::DOUBLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdcc_pkg::CFG_DEBOUNCE: debounce_ticks_reg <= cfg_data;
                bdcc_pkg::CFG_LONG:     long_ticks_reg     <= cfg_data;
                bdcc_pkg::CFG_DOUBLE:   double_ticks_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sampled_next     = sampled_reg;
        debounced_next   = debounced_reg;
        db_count_next    = db_count_reg;
        db_active_next   = db_active_reg;
        phase_next       = phase_reg;
        click_count_next = click_count_reg;
        timer_next       = timer_reg;
        gesture_next     = bdcc_pkg::G_NONE;

        unique case (func_reg)
            bdcc_pkg::FUNC_EDGE:
            begin
                // An edge inside an open window keeps the earlier sample.
                if (!db_active_reg)
                begin
                    sampled_next   = pin_reg;
                    db_count_next  = '0;
                    db_active_next = 1'b1;
                end
            end
            bdcc_pkg::FUNC_TICK:
            begin
                if (db_active_reg)
                begin
                    db_count_next = db_inc;
                    if (db_inc >= debounce_ticks_reg)
                    begin
                        if (sampled_reg == pin_reg)
                        begin
                            debounced_next = sampled_reg;
                        end
                        db_active_next = 1'b0;
                    end
                end
                if (timer_reg)
                begin
                    click_count_next = click_inc;
                    if (phase_reg == bdcc_pkg::PH_PRESSED && click_inc >= long_ticks_reg)
                    begin
                        timer_next = 1'b0;
                        phase_next = bdcc_pkg::PH_LONG;
                    end
                    else if (phase_reg == bdcc_pkg::PH_RELEASED
                             && click_inc >= double_ticks_reg)
                    begin
                        timer_next = 1'b0;
                        phase_next = bdcc_pkg::PH_SINGLE;
                    end
                end
            end
            bdcc_pkg::FUNC_POLL:
            begin
                if (debounced_reg && phase_reg == bdcc_pkg::PH_IDLE)
                begin
                    phase_next       = bdcc_pkg::PH_PRESSED;
                    click_count_next = '0;
                    timer_next       = 1'b1;
                end
                else if (!debounced_reg && phase_reg == bdcc_pkg::PH_PRESSED)
                begin
                    phase_next = bdcc_pkg::PH_RELEASED;
                end
                else if (phase_reg == bdcc_pkg::PH_RELEASED && debounced_reg)
                begin
                    // Second press before the single-click timeout.
                    timer_next   = 1'b0;
                    phase_next   = bdcc_pkg::PH_HANDLED;
                    gesture_next = bdcc_pkg::G_DOUBLE;
                end
                else if (phase_reg == bdcc_pkg::PH_LONG)
                begin
                    phase_next   = bdcc_pkg::PH_HANDLED;
                    gesture_next = bdcc_pkg::G_LONG;
                end
                else if (phase_reg == bdcc_pkg::PH_SINGLE)
                begin
                    phase_next   = bdcc_pkg::PH_HANDLED;
                    gesture_next = bdcc_pkg::G_SINGLE;
                end
                else if (phase_reg == bdcc_pkg::PH_HANDLED && !debounced_reg)
                begin
                    phase_next = bdcc_pkg::PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            sampled_reg     <= 1'b0;
            debounced_reg   <= 1'b0;
            db_count_reg    <= '0;
            db_active_reg   <= 1'b0;
            phase_reg       <= bdcc_pkg::PH_IDLE;
            click_count_reg <= '0;
            timer_reg       <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                sampled_reg     <= sampled_next;
                debounced_reg   <= debounced_next;
                db_count_reg    <= db_count_next;
                db_active_reg   <= db_active_next;
                phase_reg       <= phase_next;
                click_count_reg <= click_count_next;
                timer_reg       <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            func_reg <= s_tuser;
            pin_reg  <= s_tdata[0];
        end
        if (step)
        begin
            gesture_reg <= gesture_next;
            level_reg   <= debounced_next;
        end
    end

    // The click timer only runs between a first press and its classification.
    a_timer_phase: assert property (@(posedge clk) disable iff (!rst_n)
        timer_reg |-> (phase_reg == bdcc_pkg::PH_PRESSED
                       || phase_reg == bdcc_pkg::PH_RELEASED))
        else $error("click timer running outside a press phase");

    // Input backs up only when both registers are full and the output stalls.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a downstream stall");

    // A reported gesture always leaves the machine in the handled phase.
    a_gesture_handled: assert property (@(posedge clk) disable iff (!rst_n)
        (step && gesture_next != bdcc_pkg::G_NONE) |=> phase_reg == bdcc_pkg::PH_HANDLED)
        else $error("gesture reported without entering handled phase");

    // The debounced level moves only on a processed timer tick.
    a_level_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (step && debounced_next != debounced_reg) |-> func_reg == bdcc_pkg::FUNC_TICK)
        else $error("debounced level changed outside a tick");

endmodule
